// ===== hw/rtl/lpt_pkg.sv =====
`default_nettype none
package lpt_pkg;

   localparam int unsigned MAX_ITEMS      = 64;
   localparam int unsigned MAX_CORE_COUNT = 64;
   localparam int unsigned COST_W         = 16;
   localparam int unsigned IDX_W          = 6;
   localparam int unsigned CNT_W          = 7;
   localparam int unsigned CORE_W         = 6;
   localparam int unsigned LOAD_W         = 22;
   localparam int unsigned NCORE_W        = 7;
   localparam logic [NCORE_W-1:0] CORE_COUNT_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL_RD,
      ST_SEL_CMP,
      ST_MIN_RD,
      ST_MIN_CMP,
      ST_ASSIGN,
      ST_ELD_RD,
      ST_ELD_CMP,
      ST_EIT_RD,
      ST_EIT_CMP,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic load;
      logic sel_init;
      logic sel_step;
      logic min_init;
      logic min_step;
      logic assign_item;
      logic emit_init;
      logic eload;
      logic emit;
      logic idx_step;
      logic next_core;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic core_last;
      logic rank_last;
      logic match;
      logic slot_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lpt_core_assignment.sv =====
`default_nettype none
// longest-processing-time core assignment. requests carry one item cost each and
// are taken one per cycle while the set is loading; the request marked last closes
// the set and req_stall stays high until every result of that set has been issued
// to the result register and the set is cleared. per rank the items are scanned for
// the largest unpicked cost, then the active cores' loads for the lowest, each scan
// taking a read and a compare state per entry; the item goes to that core. emitting
// walks the item-to-core store per core, holding while a pending result is stalled,
// and a clearing state follows. results come out per core in ascending order, item
// indices ascending, each with the core's final load; overflow marks every result
// of a set in which requests beyond 64 items were dropped. the core count register
// is sampled on the closing request (0 acts as 1, above 64 acts as 64).
module lpt_core_assignment (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [lpt_pkg::NCORE_W-1:0] csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [lpt_pkg::COST_W-1:0]  req_cost,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lpt_pkg::CORE_W-1:0]       rsp_core,
   output logic [lpt_pkg::IDX_W-1:0]        rsp_item_index,
   output logic [lpt_pkg::LOAD_W-1:0]       rsp_core_load,
   output logic                             rsp_last_res,
   output logic                             rsp_overflow
);

   lpt_pkg::cmd_type    cmd;
   lpt_pkg::status_type sts;
   logic                busy;
   logic                req_accept;

   // requests only while loading
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;

   lpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_last   (req_last),
      .sts        (sts),
      .busy       (busy),
      .cmd        (cmd)
   );

   lpt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_cost       (req_cost),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_core       (rsp_core),
      .rsp_item_index (rsp_item_index),
      .rsp_core_load  (rsp_core_load),
      .rsp_last_res   (rsp_last_res),
      .rsp_overflow   (rsp_overflow)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/lpt_ctrl.sv =====
`default_nettype none
module lpt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_accept,
   input  wire logic                req_last,
   input  wire lpt_pkg::status_type sts,
   output logic                     busy,
   output lpt_pkg::cmd_type         cmd
);

   lpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpt_pkg::ST_IDLE: begin
            if (req_accept && req_last) state_in = lpt_pkg::ST_SEL_RD;
         end
         lpt_pkg::ST_SEL_RD:  state_in = lpt_pkg::ST_SEL_CMP;
         lpt_pkg::ST_SEL_CMP: begin
            state_in = sts.idx_last ? lpt_pkg::ST_MIN_RD : lpt_pkg::ST_SEL_RD;
         end
         lpt_pkg::ST_MIN_RD:  state_in = lpt_pkg::ST_MIN_CMP;
         lpt_pkg::ST_MIN_CMP: begin
            state_in = sts.core_last ? lpt_pkg::ST_ASSIGN : lpt_pkg::ST_MIN_RD;
         end
         lpt_pkg::ST_ASSIGN: begin
            state_in = sts.rank_last ? lpt_pkg::ST_ELD_RD : lpt_pkg::ST_SEL_RD;
         end
         lpt_pkg::ST_ELD_RD:  state_in = lpt_pkg::ST_ELD_CMP;
         lpt_pkg::ST_ELD_CMP: state_in = lpt_pkg::ST_EIT_RD;
         lpt_pkg::ST_EIT_RD:  state_in = lpt_pkg::ST_EIT_CMP;
         lpt_pkg::ST_EIT_CMP: begin
            if (!(sts.match && !sts.slot_free)) begin
               if (!sts.idx_last) state_in = lpt_pkg::ST_EIT_RD;
               else if (sts.core_last) state_in = lpt_pkg::ST_CLEAR;
               else state_in = lpt_pkg::ST_ELD_RD;
            end
         end
         lpt_pkg::ST_CLEAR: state_in = lpt_pkg::ST_IDLE;
         default: state_in = lpt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != lpt_pkg::ST_IDLE);
      case (state_ff)
         lpt_pkg::ST_IDLE: begin
            cmd.load     = req_accept;
            cmd.sel_init = req_accept && req_last;
         end
         lpt_pkg::ST_SEL_CMP: begin
            cmd.sel_step = 1'b1;
            cmd.min_init = sts.idx_last;
         end
         lpt_pkg::ST_MIN_CMP: cmd.min_step = 1'b1;
         lpt_pkg::ST_ASSIGN: begin
            cmd.assign_item = 1'b1;
            cmd.sel_init    = !sts.rank_last;
            cmd.emit_init   = sts.rank_last;
         end
         lpt_pkg::ST_ELD_CMP: cmd.eload = 1'b1;
         lpt_pkg::ST_EIT_CMP: begin
            if (!(sts.match && !sts.slot_free)) begin
               cmd.emit      = sts.match;
               cmd.idx_step  = !sts.idx_last;
               cmd.next_core = sts.idx_last && !sts.core_last;
            end
         end
         lpt_pkg::ST_CLEAR: cmd.clear = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lpt_dp.sv =====
`default_nettype none
module lpt_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lpt_pkg::cmd_type                   cmd,
   output lpt_pkg::status_type                     sts,
   input  wire logic                               csr_we,
   input  wire logic [lpt_pkg::NCORE_W-1:0]        csr_wdata,
   input  wire logic [lpt_pkg::COST_W-1:0]         req_cost,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [lpt_pkg::CORE_W-1:0]              rsp_core,
   output logic [lpt_pkg::IDX_W-1:0]               rsp_item_index,
   output logic [lpt_pkg::LOAD_W-1:0]              rsp_core_load,
   output logic                                    rsp_last_res,
   output logic                                    rsp_overflow
);

   logic [lpt_pkg::COST_W-1:0]  cost_mem [lpt_pkg::MAX_ITEMS];
   logic [lpt_pkg::CORE_W-1:0]  icore_mem [lpt_pkg::MAX_ITEMS];
   logic [lpt_pkg::LOAD_W-1:0]  load_mem [lpt_pkg::MAX_CORE_COUNT];

   logic [lpt_pkg::COST_W-1:0]  cost_rd_ff;
   logic [lpt_pkg::CORE_W-1:0]  icore_rd_ff;
   logic [lpt_pkg::LOAD_W-1:0]  load_rd_ff;

   logic [lpt_pkg::NCORE_W-1:0] ncores_ff;
   logic [lpt_pkg::CNT_W-1:0]   count_ff;
   logic                        drop_ff;
   logic [lpt_pkg::CORE_W-1:0]  cores_m1_ff, cores_m1_in;
   logic [lpt_pkg::IDX_W-1:0]   idx_ff, rank_ff, ecnt_ff;
   logic [lpt_pkg::CORE_W-1:0]  core_ff;
   logic                        have_best_ff;
   logic [lpt_pkg::COST_W-1:0]  best_cost_ff;
   logic [lpt_pkg::IDX_W-1:0]   best_item_ff;
   logic [lpt_pkg::LOAD_W-1:0]  best_load_ff;
   logic [lpt_pkg::CORE_W-1:0]  best_core_ff;
   logic [lpt_pkg::MAX_ITEMS-1:0]      picked_ff;
   logic [lpt_pkg::MAX_CORE_COUNT-1:0] lvalid_ff;
   logic [lpt_pkg::LOAD_W-1:0]  cur_load_ff;
   logic [lpt_pkg::LOAD_W-1:0]  load_now;
   logic [lpt_pkg::LOAD_W-1:0]  new_load;
   logic [lpt_pkg::IDX_W-1:0]   n_m1;
   logic                        full;

   logic                        rsp_valid_ff;
   logic [lpt_pkg::CORE_W-1:0]  rsp_core_ff;
   logic [lpt_pkg::IDX_W-1:0]   rsp_item_ff;
   logic [lpt_pkg::LOAD_W-1:0]  rsp_load_ff;
   logic                        rsp_last_ff, rsp_ovf_ff;

   assign full     = (count_ff == lpt_pkg::CNT_W'(lpt_pkg::MAX_ITEMS));
   assign n_m1     = lpt_pkg::IDX_W'(count_ff - lpt_pkg::CNT_W'(1));
   assign load_now = lvalid_ff[core_ff] ? load_rd_ff : '0;
   assign new_load = best_load_ff + lpt_pkg::LOAD_W'(best_cost_ff);

   always_comb begin
      cores_m1_in = lpt_pkg::CORE_W'(ncores_ff - lpt_pkg::NCORE_W'(1));
      if (ncores_ff == '0) cores_m1_in = '0;
      else if (ncores_ff > lpt_pkg::NCORE_W'(lpt_pkg::MAX_CORE_COUNT))
         cores_m1_in = lpt_pkg::CORE_W'(lpt_pkg::MAX_CORE_COUNT - 1);
   end

   assign sts.idx_last  = (idx_ff == n_m1);
   assign sts.core_last = (core_ff == cores_m1_ff);
   assign sts.rank_last = (rank_ff == n_m1);
   assign sts.match     = (icore_rd_ff == core_ff);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load && !full) cost_mem[count_ff[lpt_pkg::IDX_W-1:0]] <= req_cost;
      cost_rd_ff <= cost_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.assign_item) icore_mem[best_item_ff] <= best_core_ff;
      icore_rd_ff <= icore_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.assign_item) load_mem[best_core_ff] <= new_load;
      load_rd_ff <= load_mem[core_ff];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.sel_step && !picked_ff[idx_ff] && (!have_best_ff || cost_rd_ff > best_cost_ff)) begin
         best_cost_ff <= cost_rd_ff;
         best_item_ff <= idx_ff;
      end
      if (cmd.min_step && (core_ff == '0 || load_now < best_load_ff)) begin
         best_load_ff <= load_now;
         best_core_ff <= core_ff;
      end
      if (cmd.eload) cur_load_ff <= load_now;
      if (cmd.emit) begin
         rsp_core_ff <= core_ff;
         rsp_item_ff <= idx_ff;
         rsp_load_ff <= cur_load_ff;
         rsp_last_ff <= (ecnt_ff == n_m1);
         rsp_ovf_ff  <= drop_ff;
      end
      if (cmd.sel_init && cmd.load) cores_m1_ff <= cores_m1_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ncores_ff    <= lpt_pkg::CORE_COUNT_RESET;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         idx_ff       <= '0;
         core_ff      <= '0;
         rank_ff      <= '0;
         ecnt_ff      <= '0;
         have_best_ff <= 1'b0;
         picked_ff    <= '0;
         lvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) ncores_ff <= csr_wdata;
         if (cmd.load) begin
            if (full) drop_ff <= 1'b1;
            else count_ff <= count_ff + lpt_pkg::CNT_W'(1);
         end
         if (cmd.sel_init) begin
            idx_ff       <= '0;
            have_best_ff <= 1'b0;
         end
         if (cmd.sel_step) begin
            if (!picked_ff[idx_ff]) have_best_ff <= 1'b1;
            idx_ff <= idx_ff + lpt_pkg::IDX_W'(1);
         end
         if (cmd.min_init) core_ff <= '0;
         if (cmd.min_step) core_ff <= core_ff + lpt_pkg::CORE_W'(1);
         if (cmd.assign_item) begin
            picked_ff[best_item_ff] <= 1'b1;
            lvalid_ff[best_core_ff] <= 1'b1;
            rank_ff <= rank_ff + lpt_pkg::IDX_W'(1);
         end
         if (cmd.emit_init) begin
            core_ff <= '0;
            idx_ff  <= '0;
            ecnt_ff <= '0;
         end
         if (cmd.idx_step) idx_ff <= idx_ff + lpt_pkg::IDX_W'(1);
         if (cmd.next_core) begin
            core_ff <= core_ff + lpt_pkg::CORE_W'(1);
            idx_ff  <= '0;
         end
         if (cmd.emit) begin
            ecnt_ff      <= ecnt_ff + lpt_pkg::IDX_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.clear) begin
            count_ff  <= '0;
            drop_ff   <= 1'b0;
            rank_ff   <= '0;
            picked_ff <= '0;
            lvalid_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_core       = rsp_core_ff;
   assign rsp_item_index = rsp_item_ff;
   assign rsp_core_load  = rsp_load_ff;
   assign rsp_last_res   = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpt_pkg::CNT_W'(lpt_pkg::MAX_ITEMS))
      else $error("item count beyond capacity");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (lpt_pkg::CNT_W'(ecnt_ff) < count_ff))
      else $error("more results than stored items");

   a_core_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.assign_item |-> (best_core_ff <= cores_m1_ff))
      else $error("item given to inactive core");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free)
      else $error("result register overwritten");

endmodule
`default_nettype wire
